// ===== rtl/core/bfrf8_pkg.sv =====
package bfrf8_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;

    // default payload size
    localparam int PAYLOAD_LEN_DEF = 32;

    // register reset values
    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'd208;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'd221;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic {
        REG_FIRST_SYNC  = 1'b0,
        REG_SECOND_SYNC = 1'b1
    } t_reg_idx;

    // parser phases
    typedef enum logic [2:0] {
        S_HUNT    = 3'd0,
        S_SYNC2   = 3'd1,
        S_LEN     = 3'd2,
        S_PAYLOAD = 3'd3,
        S_CHK_A   = 3'd4,
        S_CHK_B   = 3'd5,
        S_EMIT    = 3'd6
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic seed;        // length byte accepted: seed sums, clear count
        logic accum;       // payload byte accepted: store and sum
        logic start_emit;  // check B matched: rewind read pointer
        logic emit;        // read out the stored payload
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_hit;
        logic suma_hit;
        logic sumb_hit;
        logic last_payload;
        logic emit_done;
    } t_sts;

endpackage

// ===== rtl/core/binary_frame_receiver_fletcher8.sv =====
// Channel  | Direction | Handshake               | Payload
// rx       | in        | i_rx_valid / o_rx_stall | i_rx_byte
// out      | out       | o_out_valid / i_out_stall | o_payload_byte, o_byte_index,
//          |           |                         | o_last_of_frame
// config   | in        | APB (psel, penable, ...) | first sync at 0x0, second at 0x4
//
// One received byte is taken per cycle while parsing; compares and sum updates
// finish in the cycle the byte is accepted.
// After a good check B byte the rx side stalls while the store is read out, one
// item a cycle through its registered read port while out is not stalled.
// Out stalls lengthen the readout; the last item may still wait
// in the output register while the next frame is being received.
// Reset (synchronous, active low) returns to preamble hunt with sync bytes 0xD0, 0xDD.
module binary_frame_receiver_fletcher8 #(
    parameter int PAYLOAD_LEN = bfrf8_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // received bytes
    input  logic                              i_rx_valid,
    output logic                              o_rx_stall,
    input  logic [bfrf8_pkg::BYTE_W-1:0]      i_rx_byte,
    // verified payload
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bfrf8_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [bfrf8_pkg::IDX_W-1:0]       o_byte_index,
    output logic                              o_last_of_frame,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfrf8_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bfrf8_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bfrf8_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    import bfrf8_pkg::*;

    logic [BYTE_W-1:0] r_first_sync;
    logic [BYTE_W-1:0] r_second_sync;
    logic              cfg_wr;
    t_reg_idx          reg_idx;
    t_cmd              cmd;
    t_sts              sts;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= FIRST_SYNC_RST;
            r_second_sync <= SECOND_SYNC_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FIRST_SYNC:  r_first_sync  <= pwdata[BYTE_W-1:0];
                REG_SECOND_SYNC: r_second_sync <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FIRST_SYNC:  prdata = APB_DATA_W'(r_first_sync);
            REG_SECOND_SYNC: prdata = APB_DATA_W'(r_second_sync);
            default:         prdata = '0;
        endcase
    end

    bfrf8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfrf8_dp #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_first_sync    (r_first_sync),
        .i_second_sync   (r_second_sync),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_byte_index    (o_byte_index),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== rtl/core/bfrf8_ram.sv =====
module bfrf8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bfrf8_ctrl.sv =====
module bfrf8_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rx_valid,
    output logic            o_rx_stall,
    input  bfrf8_pkg::t_sts i_sts,
    output bfrf8_pkg::t_cmd o_cmd
);

    import bfrf8_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // input is held off only while the payload is read out
    assign o_rx_stall = (r_state == S_EMIT);
    assign accept     = i_rx_valid && !o_rx_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (accept) begin
                    n_state = i_sts.sync1_hit ? S_SYNC2 : S_HUNT;
                end
            end
            S_SYNC2: begin
                if (accept) begin
                    if (i_sts.sync2_hit) begin
                        n_state = S_LEN;
                    end else begin
                        // same byte tried again as first preamble
                        n_state = i_sts.sync1_hit ? S_SYNC2 : S_HUNT;
                    end
                end
            end
            S_LEN: begin
                if (accept) begin
                    if (i_sts.len_hit) begin
                        o_cmd.seed = 1'b1;
                        n_state    = S_PAYLOAD;
                    end else begin
                        n_state = i_sts.sync1_hit ? S_SYNC2 : S_HUNT;
                    end
                end
            end
            S_PAYLOAD: begin
                if (accept) begin
                    o_cmd.accum = 1'b1;
                    if (i_sts.last_payload) begin
                        n_state = S_CHK_A;
                    end
                end
            end
            S_CHK_A: begin
                if (accept) begin
                    n_state = i_sts.suma_hit ? S_CHK_B : S_HUNT;
                end
            end
            S_CHK_B: begin
                if (accept) begin
                    if (i_sts.sumb_hit) begin
                        o_cmd.start_emit = 1'b1;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // seeding always leads into the payload phase
    a_seed_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.seed |=> r_state == S_PAYLOAD)
        else $error("seed did not enter payload phase");

    // readout is not abandoned before the datapath reports it done
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_sts.emit_done) |=> r_state == S_EMIT)
        else $error("readout left early");

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command at once");

endmodule

// ===== rtl/core/bfrf8_dp.sv =====
module bfrf8_dp #(
    parameter int PAYLOAD_LEN = bfrf8_pkg::PAYLOAD_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bfrf8_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic [bfrf8_pkg::BYTE_W-1:0]   i_first_sync,
    input  logic [bfrf8_pkg::BYTE_W-1:0]   i_second_sync,
    input  bfrf8_pkg::t_cmd                i_cmd,
    output bfrf8_pkg::t_sts                o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bfrf8_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [bfrf8_pkg::IDX_W-1:0]    o_byte_index,
    output logic                           o_last_of_frame
);

    import bfrf8_pkg::*;

    localparam int AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int CW = $clog2(PAYLOAD_LEN + 1);
    localparam logic [CW-1:0]     LEN_C  = CW'(PAYLOAD_LEN);
    localparam logic [CW-1:0]     LAST_C = CW'(PAYLOAD_LEN - 1);
    localparam logic [BYTE_W-1:0] LEN_B  = BYTE_W'(PAYLOAD_LEN);

    logic [BYTE_W-1:0] r_sum_a;
    logic [BYTE_W-1:0] r_sum_b;
    logic [BYTE_W-1:0] n_sum_a;
    logic [BYTE_W-1:0] n_sum_b;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_pend_idx;
    logic              r_pend;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;
    logic [BYTE_W-1:0] ram_rdata;
    logic              load;
    logic              issue;

    // byte compares for the controller
    assign n_sum_a = r_sum_a + i_rx_byte;
    assign n_sum_b = r_sum_b + n_sum_a;

    assign o_sts.sync1_hit    = (i_rx_byte == i_first_sync);
    assign o_sts.sync2_hit    = (i_rx_byte == i_second_sync);
    assign o_sts.len_hit      = (i_rx_byte == LEN_B);
    assign o_sts.suma_hit     = (i_rx_byte == r_sum_a);
    assign o_sts.sumb_hit     = (i_rx_byte == r_sum_b);
    assign o_sts.last_payload = (r_count == LAST_C);
    assign o_sts.emit_done    = (r_rd_ptr == LEN_C) && !r_pend;

    // Fletcher sums and write count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_count <= '0;
        end else if (i_cmd.seed) begin
            r_sum_a <= i_rx_byte;
            r_sum_b <= i_rx_byte;
            r_count <= '0;
        end else if (i_cmd.accum) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_count <= r_count + 1'b1;
        end
    end

    // readout: one read in flight, moved to the output register when free
    assign load  = r_pend && (!r_out_valid || !i_out_stall);
    assign issue = i_cmd.emit && (r_rd_ptr != LEN_C) && (!r_pend || load);

    bfrf8_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accum),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cmd.start_emit) begin
                r_rd_ptr <= '0;
            end else if (issue) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx <= r_rd_ptr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= ram_rdata;
            r_out_idx  <= IDX_W'(r_pend_idx);
            r_out_last <= (r_pend_idx == LAST_C);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out_byte;
    assign o_byte_index    = r_out_idx;
    assign o_last_of_frame = r_out_last;

    // payload writes stay inside the store
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accum |-> r_count <= LAST_C)
        else $error("payload write beyond store");

    // reads stay inside the store
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> r_rd_ptr < LEN_C)
        else $error("payload read beyond store");

    // a new readout never finds a read left over from the last one
    a_clean_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_emit |-> !r_pend)
        else $error("stale read at start of readout");

endmodule
